// ----- hw/rtl/pct_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pct_pkg;

    // Default sizing
    localparam int PCT_PEER_SLOTS = 16;
    localparam int PCT_ID_SPACE   = 4096;

    // Stream widths
    localparam int S_TDATA_W = 112;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;

    // Config port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register word selects (paddr[2])
    localparam logic REG_NAK_THR = 1'b0;
    localparam logic REG_MIN_LEN = 1'b1;

    localparam logic [7:0]  NAK_THR_RST = 8'd3;
    localparam logic [15:0] MIN_LEN_RST = 16'd256;

    // Event kinds
    localparam logic [1:0] KIND_HELLO   = 2'd0;
    localparam logic [1:0] KIND_CONFIRM = 2'd1;
    localparam logic [1:0] KIND_NAK     = 2'd2;
    localparam logic [1:0] KIND_QUERY   = 2'd3;

    // Query outcomes
    localparam logic [2:0] OUT_RAW         = 3'd0;
    localparam logic [2:0] OUT_HIT         = 3'd1;
    localparam logic [2:0] OUT_MISS_NEW    = 3'd2;
    localparam logic [2:0] OUT_MISS_COLD   = 3'd3;
    localparam logic [2:0] OUT_MISS_UNCONF = 3'd4;

    localparam logic [7:0] NAK_MAX = 8'hFF;

    typedef struct packed {
        logic [31:0] generation;
        logic        cold;
        logic [7:0]  nak_count;
    } entry_t;

    typedef struct packed {
        logic       generation_changed;
        logic       turned_cold;
        logic       table_full;
        logic [2:0] outcome;
    } result_t;

    // Status from the peer search unit
    typedef struct packed {
        logic done;
        logic found;
        logic free_found;
    } scan_flags_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pct_peer_scan.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pct_peer_scan #(
    parameter int PEER_SLOTS = pct_pkg::PCT_PEER_SLOTS,
    parameter int SLOT_W     = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire logic [31:0]         key,
    input  wire logic                add_en,
    input  wire logic [SLOT_W-1:0]   add_idx,
    input  wire logic [31:0]         add_key,
    output pct_pkg::scan_flags_t     flags,
    output logic      [SLOT_W-1:0]   hit_idx,
    output logic      [SLOT_W-1:0]   free_idx
);
    import pct_pkg::*;

    localparam logic [SLOT_W:0] SLOTS_N = (SLOT_W + 1)'(PEER_SLOTS);

    logic [31:0]           key_mem [PEER_SLOTS];
    logic [PEER_SLOTS-1:0] used_reg;
    logic [SLOT_W:0]       scan_idx_reg;
    logic [SLOT_W-1:0]     cmp_idx_reg;
    logic                  cmp_vld_reg;
    logic [31:0]           key_rd_reg;
    logic [31:0]           key_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic                  found_reg;
    logic                  free_found_reg;
    logic [SLOT_W-1:0]     hit_idx_reg;
    logic [SLOT_W-1:0]     free_idx_reg;

    logic              issuing;
    logic              match;
    logic              finish;
    logic [SLOT_W-1:0] rd_idx;

    assign rd_idx  = scan_idx_reg[SLOT_W-1:0];
    assign issuing = busy_reg && (scan_idx_reg < SLOTS_N);
    // the one shared comparator: one slot per cycle
    assign match   = cmp_vld_reg && used_reg[cmp_idx_reg] && (key_rd_reg == key_reg);
    assign finish  = busy_reg && (match || !issuing);

    always_ff @(posedge aclk) begin
        if (add_en) begin
            key_mem[add_idx] <= add_key;
        end
        key_rd_reg <= key_mem[rd_idx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg       <= '0;
            busy_reg       <= 1'b0;
            done_reg       <= 1'b0;
            cmp_vld_reg    <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end else begin
            done_reg <= finish;
            if (start) begin
                busy_reg       <= 1'b1;
                scan_idx_reg   <= '0;
                key_reg        <= key;
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
                cmp_vld_reg    <= 1'b0;
            end else if (busy_reg) begin
                cmp_vld_reg <= issuing && !match;
                if (issuing && !match) begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                    cmp_idx_reg  <= rd_idx;
                    if (!used_reg[rd_idx] && !free_found_reg) begin
                        free_found_reg <= 1'b1;
                        free_idx_reg   <= rd_idx;
                    end
                end
                if (finish) begin
                    busy_reg  <= 1'b0;
                    found_reg <= match;
                    if (match) begin
                        hit_idx_reg <= cmp_idx_reg;
                    end
                end
            end
            if (add_en) begin
                used_reg[add_idx] <= 1'b1;
            end
        end
    end

    assign flags.done       = done_reg;
    assign flags.found      = found_reg;
    assign flags.free_found = free_found_reg;
    assign hit_idx          = hit_idx_reg;
    assign free_idx         = free_idx_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/pct_bitmap.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pct_bitmap #(
    parameter int ADDR_W = $clog2(pct_pkg::PCT_PEER_SLOTS * pct_pkg::PCT_ID_SPACE / 64)
) (
    input  wire logic              aclk,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [63:0]       rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [63:0]       wr_data
);
    import pct_pkg::*;

    localparam int DEPTH = 2 ** ADDR_W;

    logic [63:0] mem [DEPTH];
    logic [63:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/peer_confirmation_tracker_core.sv -----
// Peer confirmation tracker: a table of peers with per-peer bitmaps of
// confirmed chunk ids, for a deduplicating link.
// Input channel s_axis: one item per event, kind in tuser (hello, confirm,
// nak, query); tdata carries peer key, generation, chunk id and length.
// Result channel m_axis: exactly one item per input item, in order.
// Config: APB-style port, nak_cold_threshold at 0x0, min_chunk_length at
// 0x4; write only while no item is in flight.
// Flow: one item at a time. A raw query or a query with no chunk id
// goes from accept straight to the done state, which loads the result
// into the output register. Every other item runs the peer search, which
// steps one shared key comparator over one slot per cycle. Adding a peer
// or a generation change also wipes that peer's bitmap at one 64-bit word
// per cycle. s_axis_tready is high only when idle.
// Reset: all slots free, registers at their reset values. The bitmap
// memory needs no clearing pass, since a slot's bitmap is wiped whenever
// a peer is added to it, before any access.
// Stall: a finished result waits in the output register; the sequencer
// holds in its done state until m_axis_tready lets it load the next one.
`timescale 1ns / 1ps
`default_nettype none

module peer_confirmation_tracker_core #(
    parameter int PEER_SLOTS = pct_pkg::PCT_PEER_SLOTS,
    parameter int ID_SPACE   = pct_pkg::PCT_ID_SPACE
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // s_axis: tuser = kind[1:0]
    // tdata = key[31:0], peer_generation[63:32], chunk_id[95:64],
    //         chunk_length[111:96]
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [pct_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  wire logic [pct_pkg::S_TUSER_W-1:0] s_axis_tuser,
    // m_axis: tdata = outcome[2:0], table_full[3], turned_cold[4],
    //         generation_changed[5], zero[7:6]
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic      [pct_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // config
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [pct_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [pct_pkg::PDATA_W-1:0]   pwdata,
    output logic      [pct_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready
);
    import pct_pkg::*;

    localparam int SLOT_W = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
    localparam int WORDS  = (ID_SPACE + 63) / 64;
    localparam int WORD_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BM_AW  = SLOT_W + WORD_W;

    localparam logic [WORD_W-1:0] WORD_LAST = WORD_W'(WORDS - 1);
    localparam logic [31:0]       ID_MAX    = 32'(ID_SPACE);

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_WIPE   = 3'd2;
    localparam logic [2:0] ST_ENT_RD = 3'd3;
    localparam logic [2:0] ST_EVENT  = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0]        state_reg,     state_next;
    logic [1:0]        kind_reg,      kind_next;
    logic [31:0]       gen_reg,       gen_next;
    logic [31:0]       cid_reg,       cid_next;
    logic [SLOT_W-1:0] slot_reg,      slot_next;
    logic [WORD_W-1:0] wipe_word_reg, wipe_word_next;
    logic              wipe_ent_reg,  wipe_ent_next;
    result_t           res_reg,       res_next;
    logic [M_TDATA_W-1:0] out_reg,    out_next;
    logic              m_valid_reg,   m_valid_next;
    logic [7:0]        nak_thr_reg;
    logic [15:0]       min_len_reg;

    // entry store
    entry_t ent_mem [PEER_SLOTS];
    entry_t ent_rd_reg;
    logic   ent_we;
    logic [SLOT_W-1:0] ent_waddr;
    entry_t ent_wdata;

    // bitmap port
    logic [BM_AW-1:0] bm_raddr;
    logic [63:0]      bm_rdata;
    logic             bm_we;
    logic [BM_AW-1:0] bm_waddr;
    logic [63:0]      bm_wdata;

    // peer search
    scan_flags_t       scan_flags;
    logic [SLOT_W-1:0] hit_idx;
    logic [SLOT_W-1:0] free_idx;
    logic              scan_start;
    logic              add_en;

    // input fields
    logic        s_accept;
    logic [31:0] in_key;
    logic [31:0] in_gen;
    logic [31:0] in_cid;
    logic [15:0] in_len;
    // key of the item in flight, for a peer add
    logic [31:0] key_hold_reg;

    // chunk id decode
    logic              id_valid;
    logic [31:0]       cid_m1;
    logic [WORD_W-1:0] word_idx;
    logic [63:0]       bit_mask;
    logic [7:0]        nak_inc;
    logic              nak_turns_cold;
    logic              cfg_wr;

    assign in_key   = s_axis_tdata[31:0];
    assign in_gen   = s_axis_tdata[63:32];
    assign in_cid   = s_axis_tdata[95:64];
    assign in_len   = s_axis_tdata[111:96];
    assign s_accept = s_axis_tvalid && s_axis_tready;

    assign cid_m1   = cid_reg - 32'd1;
    assign id_valid = (cid_reg != 32'd0) && (cid_reg <= ID_MAX);
    assign word_idx = cid_m1[6 +: WORD_W];
    assign bit_mask = 64'd1 << cid_m1[5:0];
    assign bm_raddr = {slot_reg, word_idx};

    assign nak_inc        = (ent_rd_reg.nak_count == NAK_MAX) ? NAK_MAX
                                                              : ent_rd_reg.nak_count + 8'd1;
    assign nak_turns_cold = !ent_rd_reg.cold && (nak_inc >= nak_thr_reg);

    pct_peer_scan #(
        .PEER_SLOTS (PEER_SLOTS),
        .SLOT_W     (SLOT_W)
    ) u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (scan_start),
        .key      (in_key),
        .add_en   (add_en),
        .add_idx  (free_idx),
        .add_key  (key_hold_reg),
        .flags    (scan_flags),
        .hit_idx  (hit_idx),
        .free_idx (free_idx)
    );

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            key_hold_reg <= in_key;
        end
    end

    pct_bitmap #(
        .ADDR_W (BM_AW)
    ) u_bitmap (
        .aclk    (aclk),
        .rd_addr (bm_raddr),
        .rd_data (bm_rdata),
        .wr_en   (bm_we),
        .wr_addr (bm_waddr),
        .wr_data (bm_wdata)
    );

    always_ff @(posedge aclk) begin
        if (ent_we) begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        ent_rd_reg <= ent_mem[slot_reg];
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        gen_next       = gen_reg;
        cid_next       = cid_reg;
        slot_next      = slot_reg;
        wipe_word_next = wipe_word_reg;
        wipe_ent_next  = wipe_ent_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        scan_start     = 1'b0;
        add_en         = 1'b0;
        ent_we         = 1'b0;
        ent_waddr      = slot_reg;
        ent_wdata      = ent_rd_reg;
        bm_we          = 1'b0;
        bm_waddr       = bm_raddr;
        bm_wdata       = bm_rdata;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    kind_next = s_axis_tuser;
                    gen_next  = in_gen;
                    cid_next  = in_cid;
                    res_next  = '0;
                    if (s_axis_tuser == KIND_QUERY &&
                        (in_len == 16'd0 || in_len < min_len_reg)) begin
                        res_next.outcome = OUT_RAW;
                        state_next       = ST_DONE;
                    end else if (s_axis_tuser == KIND_QUERY && in_cid == 32'd0) begin
                        res_next.outcome = OUT_MISS_NEW;
                        state_next       = ST_DONE;
                    end else begin
                        scan_start = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_flags.done) begin
                    if (scan_flags.found) begin
                        slot_next  = hit_idx;
                        state_next = ST_ENT_RD;
                    end else if (kind_reg == KIND_QUERY) begin
                        // absent peer: warm, nothing confirmed
                        res_next.outcome = OUT_MISS_UNCONF;
                        state_next       = ST_DONE;
                    end else if (scan_flags.free_found) begin
                        // new peer: cold, generation 0, bitmap wiped
                        add_en         = 1'b1;
                        ent_we         = 1'b1;
                        ent_waddr      = free_idx;
                        ent_wdata      = '{generation: 32'd0, cold: 1'b1, nak_count: 8'd0};
                        slot_next      = free_idx;
                        wipe_word_next = '0;
                        wipe_ent_next  = 1'b1;
                        state_next     = ST_WIPE;
                    end else begin
                        res_next.table_full = 1'b1;
                        state_next          = ST_DONE;
                    end
                end
            end
            ST_WIPE: begin
                bm_we    = 1'b1;
                bm_waddr = {slot_reg, wipe_word_reg};
                bm_wdata = '0;
                if (wipe_word_reg == WORD_LAST) begin
                    state_next = wipe_ent_reg ? ST_ENT_RD : ST_DONE;
                end else begin
                    wipe_word_next = wipe_word_reg + 1'b1;
                end
            end
            ST_ENT_RD: begin
                // entry and bitmap word are read here, used next cycle
                state_next = ST_EVENT;
            end
            ST_EVENT: begin
                state_next = ST_DONE;
                case (kind_reg)
                    KIND_QUERY: begin
                        if (ent_rd_reg.cold) begin
                            res_next.outcome = OUT_MISS_COLD;
                        end else if (id_valid && ((bm_rdata & bit_mask) != 64'd0)) begin
                            res_next.outcome = OUT_HIT;
                        end else begin
                            res_next.outcome = OUT_MISS_UNCONF;
                        end
                    end
                    KIND_HELLO: begin
                        ent_we = 1'b1;
                        if (ent_rd_reg.generation != 32'd0 &&
                            ent_rd_reg.generation != gen_reg) begin
                            ent_wdata = '{generation: gen_reg, cold: 1'b1, nak_count: 8'd0};
                            res_next.turned_cold        = 1'b1;
                            res_next.generation_changed = 1'b1;
                            wipe_word_next = '0;
                            wipe_ent_next  = 1'b0;
                            state_next     = ST_WIPE;
                        end else begin
                            ent_wdata = '{generation: gen_reg, cold: 1'b0, nak_count: 8'd0};
                        end
                    end
                    KIND_CONFIRM: begin
                        bm_we    = id_valid;
                        bm_wdata = bm_rdata | bit_mask;
                    end
                    default: begin
                        // nak
                        bm_we     = id_valid;
                        bm_wdata  = bm_rdata & ~bit_mask;
                        ent_we    = 1'b1;
                        ent_wdata = '{generation: ent_rd_reg.generation,
                                      cold: ent_rd_reg.cold || nak_turns_cold,
                                      nak_count: nak_inc};
                        res_next.turned_cold = nak_turns_cold;
                    end
                endcase
            end
            ST_DONE: begin
                if (!m_valid_reg || m_axis_tready) begin
                    out_next     = {2'b00, res_reg.generation_changed, res_reg.turned_cold,
                                    res_reg.table_full, res_reg.outcome};
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        kind_reg      <= kind_next;
        gen_reg       <= gen_next;
        cid_reg       <= cid_next;
        slot_reg      <= slot_next;
        wipe_word_reg <= wipe_word_next;
        wipe_ent_reg  <= wipe_ent_next;
        res_reg       <= res_next;
        out_reg       <= out_next;
    end

    // config registers
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nak_thr_reg <= NAK_THR_RST;
            min_len_reg <= MIN_LEN_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_NAK_THR: nak_thr_reg <= pwdata[7:0];
                REG_MIN_LEN: min_len_reg <= pwdata[15:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_NAK_THR: prdata = {24'd0, nak_thr_reg};
            REG_MIN_LEN: prdata = {16'd0, min_len_reg};
        endcase
    end

    assign pready        = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = out_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/pct_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pct_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_axis_tvalid,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata
);

    // results come out of reset empty
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // one item in flight: input closes right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready right after accept");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

    // a full table reports nothing else
    a_full_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tdata[3]) |->
        (m_axis_tdata[2:0] == 3'd0 && !m_axis_tdata[4] && !m_axis_tdata[5]))
        else $error("table_full with other flags");

    // a generation change always marks the peer cold
    a_gen_cold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tdata[5]) |->
        (m_axis_tdata[4] && m_axis_tdata[2:0] == 3'd0))
        else $error("generation change without turned_cold");

endmodule

bind peer_confirmation_tracker_core pct_checker u_pct_checker (.*);

`default_nettype wire

// ----- test/tb_peer_confirmation_tracker_core.sv -----
`timescale 1ns / 1ps

module tb_peer_confirmation_tracker_core;

    import pct_pkg::*;

    localparam int SLOTS = PCT_PEER_SLOTS;
    localparam int IDS   = PCT_ID_SPACE;
    localparam int WORDS = (IDS + 63) / 64;

    // register addresses: one 32-bit word per register
    localparam logic [PADDR_W-1:0] ADDR_NAK_THR = {REG_NAK_THR, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_MIN_LEN = {REG_MIN_LEN, 2'b00};

    // receiver stall patterns
    typedef enum int {RX_FREE, RX_COIN, RX_EVERY5, RX_SPARSE} rx_mode_t;

    // one pending event for the driver
    typedef struct {
        logic [1:0]  kind;
        logic [31:0] key;
        logic [31:0] gen;
        logic [31:0] cid;
        logic [15:0] len;
        bit          hold;   // wait until every outstanding result is back
    } peer_event_t;

    // ---------------------------------------------------------------
    // DUT ports; every driven input starts at a known value from time zero
    // ---------------------------------------------------------------
    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // tdata: key, peer_generation, chunk_id, chunk_length (low bits first)
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    // tuser: kind
    logic [S_TUSER_W-1:0] s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // tdata: outcome, table_full, turned_cold, generation_changed, zero pad
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 psel          = 1'b0;
    logic                 penable       = 1'b0;
    logic                 pwrite        = 1'b0;
    logic [PADDR_W-1:0]   paddr         = '0;
    logic [PDATA_W-1:0]   pwdata        = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    peer_confirmation_tracker_core uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // Shadow of the peer table and the registers
    // ---------------------------------------------------------------
    bit        peer_used  [SLOTS];
    bit [31:0] shadow_key [SLOTS];
    bit [31:0] peer_gen   [SLOTS];
    bit        peer_cold  [SLOTS];
    bit [7:0]  peer_naks  [SLOTS];
    bit [63:0] chunk_map  [SLOTS][WORDS];
    bit [7:0]  cold_threshold = NAK_THR_RST;
    bit [15:0] raw_below_len  = MIN_LEN_RST;

    peer_event_t event_backlog[$];
    result_t     pending_results[$];
    result_t     seen_result;
    result_t     due_result;
    peer_event_t next_event;

    int accepted_count = 0;
    int driven_count   = 0;
    int fail_count     = 0;
    int burst_left     = 0;
    int gap_left       = 0;
    int stim_items     = 0;

    rx_mode_t rx_mode = RX_FREE;
    int       rx_span = 0;
    int       rx_tick = 0;

    // stimulus-side view: peers in use and their last announced generation
    logic [31:0] pool_key [SLOTS];
    logic [31:0] gen_hint [SLOTS];
    logic [15:0] stim_min_len = MIN_LEN_RST;

    function automatic int find_peer(input logic [31:0] key);
        for (int i = 0; i < SLOTS; i++)
            if (peer_used[i] && shadow_key[i] == key)
                return i;
        return -1;
    endfunction

    function automatic void wipe_map(input int slot);
        for (int w = 0; w < WORDS; w++)
            chunk_map[slot][w] = '0;
    endfunction

    // ids 1..IDS are tracked; 0 and anything above is ignored
    function automatic bit chunk_in_range(input logic [31:0] cid);
        return cid != 32'd0 && cid <= IDS;
    endfunction

    function automatic void mark_chunk(input int slot, input logic [31:0] cid, input bit val);
        if (chunk_in_range(cid))
            chunk_map[slot][(cid - 1) >> 6][(cid - 1) & 63] = val;
    endfunction

    // Expected result of one event; updates the shadow table.
    function automatic result_t track_event(input logic [1:0] kind, input logic [31:0] key,
                                            input logic [31:0] gen, input logic [31:0] cid,
                                            input logic [15:0] len);
        result_t res;
        int      slot;
        res = '0;
        if (kind == KIND_QUERY) begin
            // queries never add a peer; an absent peer looks warm and empty
            if (len == 16'd0 || len < raw_below_len) begin
                res.outcome = OUT_RAW;
            end else begin
                slot = find_peer(key);
                if (cid == 32'd0)
                    res.outcome = OUT_MISS_NEW;
                else if (slot >= 0 && peer_cold[slot])
                    res.outcome = OUT_MISS_COLD;
                else if (slot >= 0 && chunk_in_range(cid)
                         && chunk_map[slot][(cid - 1) >> 6][(cid - 1) & 63])
                    res.outcome = OUT_HIT;
                else
                    res.outcome = OUT_MISS_UNCONF;
            end
        end else begin
            slot = find_peer(key);
            // new peer: lowest free slot, cleared, starts cold
            for (int i = 0; i < SLOTS && slot < 0; i++) begin
                if (!peer_used[i]) begin
                    peer_used[i]  = 1'b1;
                    shadow_key[i] = key;
                    peer_gen[i]   = '0;
                    peer_cold[i]  = 1'b1;
                    peer_naks[i]  = '0;
                    wipe_map(i);
                    slot = i;
                end
            end
            if (slot < 0) begin
                res.table_full = 1'b1;
            end else if (kind == KIND_HELLO) begin
                if (peer_gen[slot] != 0 && peer_gen[slot] != gen) begin
                    peer_gen[slot]  = gen;
                    peer_cold[slot] = 1'b1;
                    peer_naks[slot] = '0;
                    wipe_map(slot);
                    res.turned_cold        = 1'b1;
                    res.generation_changed = 1'b1;
                end else begin
                    peer_gen[slot]  = gen;
                    peer_cold[slot] = 1'b0;
                    peer_naks[slot] = '0;
                end
            end else if (kind == KIND_CONFIRM) begin
                mark_chunk(slot, cid, 1'b1);
            end else begin
                mark_chunk(slot, cid, 1'b0);
                if (peer_naks[slot] != NAK_MAX)
                    peer_naks[slot]++;
                if (!peer_cold[slot] && peer_naks[slot] >= cold_threshold) begin
                    peer_cold[slot] = 1'b1;
                    res.turned_cold = 1'b1;
                end
            end
        end
        return res;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // ---------------------------------------------------------------
    // Monitor: predict on input accept, compare on result accept
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                pending_results.push_back(track_event(s_axis_tuser, s_axis_tdata[31:0],
                    s_axis_tdata[63:32], s_axis_tdata[95:64], s_axis_tdata[111:96]));
                accepted_count++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                seen_result = result_t'(m_axis_tdata[5:0]);
                if (pending_results.size() == 0) begin
                    $error("result with no event outstanding: tdata %h", m_axis_tdata);
                    fail_count++;
                end else begin
                    due_result = pending_results.pop_front();
                    check_field("outcome", due_result.outcome, seen_result.outcome);
                    check_field("table_full", due_result.table_full, seen_result.table_full);
                    check_field("turned_cold", due_result.turned_cold,
                                seen_result.turned_cold);
                    check_field("generation_changed", due_result.generation_changed,
                                seen_result.generation_changed);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Driver: bursts of items with random gaps after each burst
    // ---------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && accepted_count != driven_count) begin
            // item still waiting for tready, keep it on the bus
        end else if (gap_left > 0) begin
            gap_left--;
            s_axis_tvalid <= 1'b0;
        end else if (event_backlog.size() != 0
                     && (!event_backlog[0].hold || pending_results.size() == 0)) begin
            next_event = event_backlog.pop_front();
            s_axis_tvalid <= 1'b1;
            s_axis_tuser  <= next_event.kind;
            s_axis_tdata  <= {next_event.len, next_event.cid, next_event.gen, next_event.key};
            driven_count++;
            if (burst_left > 0)
                burst_left--;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: gap_left = 0;
                    4, 5, 6:    gap_left = $urandom_range(1, 4);
                    default:    gap_left = $urandom_range(5, 40);
                endcase
            end
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Receiver: stall pattern switches after a randomly drawn span of cycles
    // ---------------------------------------------------------------
    always @(negedge aclk) begin
        if (rx_span == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_span = $urandom_range(30, 400);
        end else begin
            rx_span--;
        end
        rx_tick++;
        case (rx_mode)
            RX_FREE:   m_axis_tready <= 1'b1;
            RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
            RX_EVERY5: m_axis_tready <= (rx_tick % 5 == 0);
            default:   m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // ---------------------------------------------------------------
    // Config port
    // ---------------------------------------------------------------
    task automatic cfg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic cfg_read(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] want);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== want) begin
            $error("prdata at %h: expected %h, got %h", addr, want, prdata);
            fail_count++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // only called while the block is idle
    task automatic set_config(input logic [7:0] thr, input logic [15:0] min_len);
        cfg_write(ADDR_NAK_THR, {24'd0, thr});
        cfg_write(ADDR_MIN_LEN, {16'd0, min_len});
        cold_threshold = thr;
        raw_below_len  = min_len;
        stim_min_len   = min_len;
        cfg_read(ADDR_NAK_THR, {24'd0, thr});
        cfg_read(ADDR_MIN_LEN, {16'd0, min_len});
    endtask

    // idle: nothing queued or on the bus, every result back, block ready
    task automatic wait_idle();
        while (!(event_backlog.size() == 0 && driven_count == accepted_count
                 && pending_results.size() == 0 && s_axis_tready))
            @(negedge aclk);
    endtask

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    task automatic push_event(input logic [1:0] kind, input logic [31:0] key,
                              input logic [31:0] gen, input logic [31:0] cid,
                              input logic [15:0] len, input bit hold = 1'b0);
        peer_event_t ev;
        ev.kind = kind;
        ev.key  = key;
        ev.gen  = gen;
        ev.cid  = cid;
        ev.len  = len;
        ev.hold = hold;
        event_backlog.push_back(ev);
        stim_items++;
    endtask

    // mostly low ids so queries hit confirmed chunks; edges and junk too
    function automatic logic [31:0] pick_chunk();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return $urandom_range(1, 96);
        if (r < 65) return $urandom_range(1, IDS);
        if (r < 72) return 32'd0;
        if (r < 78) return IDS;
        if (r < 82) return IDS + 1;
        if (r < 86) return 32'd1;
        return $urandom;
    endfunction

    function automatic logic [15:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)  return 16'd0;
        if (r < 15) return 16'($urandom_range(0, 65535));
        if (r < 22) return 16'hFFFF;
        if (r < 30) return (stim_min_len == 0) ? 16'd0 : stim_min_len - 16'd1;
        return 16'($urandom_range(stim_min_len, 65535));
    endfunction

    function automatic logic [31:0] pick_key();
        if ($urandom_range(0, 7) == 0)
            return $urandom;
        return pool_key[$urandom_range(0, SLOTS - 1)];
    endfunction

    // hello, a few confirms, queries mostly on those ids, sometimes naks
    task automatic add_session();
        int          idx;
        int          nids;
        int          r;
        logic [31:0] key;
        logic [31:0] gen;
        logic [31:0] ids [4];
        logic [31:0] cid;
        idx = $urandom_range(0, SLOTS - 1);
        key = ($urandom_range(0, 9) == 0) ? $urandom : pool_key[idx];
        r = $urandom_range(0, 99);
        if (r < 70) begin
            gen = gen_hint[idx];
        end else if (r < 85) begin
            gen = $urandom;
            gen_hint[idx] = gen;
        end else if (r < 93) begin
            gen = '0;
            gen_hint[idx] = gen;
        end else begin
            gen = $urandom;
        end
        push_event(KIND_HELLO, key, gen, $urandom, 16'($urandom_range(0, 65535)),
                   $urandom_range(0, 29) == 0);
        nids = $urandom_range(0, 4);
        for (int i = 0; i < nids; i++) begin
            ids[i] = pick_chunk();
            push_event(KIND_CONFIRM, key, $urandom, ids[i], 16'($urandom_range(0, 65535)));
        end
        for (int i = $urandom_range(1, 4); i > 0; i--) begin
            cid = (nids > 0 && $urandom_range(0, 9) < 7) ? ids[$urandom_range(0, nids - 1)]
                                                         : pick_chunk();
            push_event(KIND_QUERY, key, $urandom, cid, pick_length());
        end
        if ($urandom_range(0, 9) < 3) begin
            for (int i = $urandom_range(1, 5); i > 0; i--)
                push_event(KIND_NAK, key, $urandom, pick_chunk(),
                           16'($urandom_range(0, 65535)));
            push_event(KIND_QUERY, key, $urandom, pick_chunk(), pick_length());
        end
    endtask

    initial begin
        logic [31:0] cand;
        logic [31:0] outsider;
        logic [7:0]  thr;
        logic [15:0] min_len;
        bit          clash;
        int          goal;

        // peer keys: all-zero and all-one keys plus distinct random ones
        outsider    = 32'h5A5A_0001;
        pool_key[0] = 32'h0000_0000;
        pool_key[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < SLOTS; i++) begin
            do begin
                cand  = $urandom;
                clash = (cand == outsider);
                for (int j = 0; j < i; j++)
                    if (pool_key[j] == cand)
                        clash = 1'b1;
            end while (clash);
            pool_key[i] = cand;
        end
        for (int i = 0; i < SLOTS; i++)
            gen_hint[i] = '0;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        cfg_read(ADDR_NAK_THR, {24'd0, NAK_THR_RST});
        cfg_read(ADDR_MIN_LEN, {16'd0, MIN_LEN_RST});

        // ---- directed, reset register values (threshold 3, min length 256)
        push_event(KIND_QUERY, pool_key[0], '0, 32'd7, 16'd0);      // zero length: raw
        push_event(KIND_QUERY, pool_key[0], '0, 32'd7, 16'd255);    // below min: raw
        push_event(KIND_QUERY, pool_key[0], '0, 32'd0, 16'd256);    // no local id: miss new
        push_event(KIND_QUERY, pool_key[0], '0, 32'd5, 16'hFFFF);   // absent peer is warm
        push_event(KIND_CONFIRM, pool_key[0], '0, 32'd1, 16'd0);    // adds peer, cold
        push_event(KIND_QUERY, pool_key[0], '0, 32'd1, 16'd300);    // miss cold
        push_event(KIND_HELLO, pool_key[0], '0, 32'd0, 16'd0);      // first hello, gen 0
        push_event(KIND_QUERY, pool_key[0], '0, 32'd1, 16'd300);    // bitmap kept: hit
        push_event(KIND_HELLO, pool_key[0], 32'hFFFF_FFFF, '0, '0); // known gen 0: taken
        push_event(KIND_HELLO, pool_key[0], 32'hFFFF_FFFF, '0, '0); // same gen
        push_event(KIND_CONFIRM, pool_key[0], '0, IDS, 16'd0);
        push_event(KIND_CONFIRM, pool_key[0], '0, IDS + 1, 16'd0);  // out of range: ignored
        push_event(KIND_CONFIRM, pool_key[0], '0, 32'hFFFF_FFFF, 16'd0);
        push_event(KIND_QUERY, pool_key[0], '0, IDS, 16'd256);      // hit
        push_event(KIND_QUERY, pool_key[0], '0, IDS + 1, 16'd256);  // reads as unconfirmed
        push_event(KIND_NAK, pool_key[0], '0, IDS, 16'd0);          // clears, count 1
        push_event(KIND_QUERY, pool_key[0], '0, IDS, 16'd256);
        push_event(KIND_NAK, pool_key[0], '0, 32'd0, 16'd0);
        push_event(KIND_NAK, pool_key[0], '0, IDS + 1, 16'd0);      // third: turns cold
        push_event(KIND_HELLO, pool_key[0], 32'd5, '0, '0);         // gen change: wipe
        push_event(KIND_QUERY, pool_key[0], '0, 32'd1, 16'd256);
        push_event(KIND_HELLO, pool_key[0], 32'd5, '0, '0);
        push_event(KIND_QUERY, pool_key[0], '0, 32'd1, 16'd256);    // wiped: unconfirmed
        push_event(KIND_HELLO, pool_key[1], 32'd7, '0, '0);
        gen_hint[0] = 32'd5;
        gen_hint[1] = 32'd7;

        // ---- directed, threshold 0 and min length 0, then fill the table
        wait_idle();
        set_config(8'd0, 16'd0);
        push_event(KIND_HELLO, pool_key[0], 32'd5, '0, '0);
        push_event(KIND_NAK, pool_key[0], '0, 32'd1, 16'd0);        // cold at first nak
        push_event(KIND_QUERY, pool_key[0], '0, 32'd1, 16'd0);      // zero length still raw
        push_event(KIND_QUERY, pool_key[1], '0, 32'd0, 16'd1);
        for (int i = 2; i < SLOTS; i++)
            push_event(KIND_CONFIRM, pool_key[i], '0, i, 16'd0);
        push_event(KIND_HELLO, outsider, 32'd9, '0, '0);            // table full
        push_event(KIND_CONFIRM, outsider, '0, 32'd3, '0);
        push_event(KIND_NAK, outsider, '0, 32'd3, '0);
        push_event(KIND_QUERY, outsider, '0, 32'd3, 16'd100);       // query never full

        // ---- random phases over several register settings
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin thr = 8'd1;   min_len = 16'd0;    end
                1: begin thr = 8'd255; min_len = 16'd1;    end
                2: begin thr = 8'd2;   min_len = 16'hFFFF; end
                3: begin
                    thr     = 8'($urandom_range(1, 8));
                    min_len = 16'($urandom_range(0, 600));
                end
                default: begin thr = NAK_THR_RST; min_len = MIN_LEN_RST; end
            endcase
            wait_idle();
            set_config(thr, min_len);
            goal = stim_items + 225;
            if (thr == 8'd255) begin
                // long nak run: cold at 255, count saturates after
                push_event(KIND_HELLO, pool_key[3], gen_hint[3], '0, '0);
                push_event(KIND_HELLO, pool_key[3], gen_hint[3], '0, '0);
                for (int i = 0; i < 258; i++)
                    push_event(KIND_NAK, pool_key[3], $urandom, pick_chunk(),
                               16'($urandom_range(0, 65535)));
                push_event(KIND_QUERY, pool_key[3], '0, 32'd0, 16'hFFFF);
            end
            while (stim_items < goal) begin
                if ($urandom_range(0, 3) != 0)
                    add_session();
                else
                    push_event(2'($urandom_range(0, 3)), pick_key(), $urandom,
                               $urandom_range(0, 1) ? $urandom : pick_chunk(), pick_length());
            end
        end

        wait_idle();
        // catch any stray result after the last one
        repeat (200) @(posedge aclk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #6000000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/pct_pkg.sv
hw/rtl/pct_peer_scan.sv
hw/rtl/pct_bitmap.sv
hw/rtl/peer_confirmation_tracker_core.sv
hw/rtl/pct_checker.sv
test/tb_peer_confirmation_tracker_core.sv
